// ===== hw/rtl/wrf_pkg.sv =====
// Shared types and constants for the whole-word find and replace filter.
// Used by the interfaces' users, front, queue, back sequencer and top level.
// No dependencies.
package wrf_pkg;

  localparam int WORD_MAX = 8;                      // longest buffered word
  localparam int IDX_W    = $clog2(WORD_MAX);
  localparam int CNT_W    = $clog2(WORD_MAX + 1);
  localparam int BODY_W   = 8 * WORD_MAX;
  localparam int RUN_W    = $clog2(WORD_MAX + 4);   // results per command, plus one

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 64;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_WORD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LENGTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPL_WORD     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPL_LENGTH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DELIMITER     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_CASE    = 3'd5;

  localparam logic [7:0] DELIMITER_RESET = 8'h20;

  typedef struct packed {
    logic [63:0] target_word;
    logic [3:0]  target_length;
    logic [63:0] replacement_word;
    logic [3:0]  replacement_length;
    logic [7:0]  delimiter;
    logic        match_case;
  } cfg_t;

  // One run of results: [delimiter] [body bytes] [tail byte] [end marker]
  typedef struct packed {
    logic              sep;
    logic [CNT_W-1:0]  body_len;
    logic [BODY_W-1:0] body;
    logic              tail;
    logic [7:0]        tail_byte;
    logic              eot;
  } cmd_t;

endpackage

// ===== hw/rtl/wrf_if.sv =====
// Valid/ready stream interfaces for the text input and the rewritten output.
// No dependencies.
interface wrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_mark;

  modport source (output valid, output text_byte, output end_mark, input ready);
  modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

interface wrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_text;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_text,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/wrf_front.sv =====
// Front end: accepts text bytes, buffers the current word, compares it with
// the target and issues result-run commands. Depends on wrf_pkg, wrf_if.
module wrf_front
  import wrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  wrf_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5a;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic mc);
    if (!mc && c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

  logic [7:0]        word_store [WORD_MAX];
  logic [CNT_W-1:0]  word_count, word_count_next;
  logic              passing, passing_next;
  logic              any_out, any_out_next;
  logic              store_we;
  logic              accept;
  logic              bytes_eq;
  logic              match;
  logic [BODY_W-1:0] word_vec;
  logic [CNT_W-1:0]  repl_len;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < WORD_MAX; i++) begin
      word_vec[8*i +: 8] = word_store[i];
      if (CNT_W'(i) < word_count &&
          fold(word_store[i], cfg.match_case) != fold(cfg.target_word[8*i +: 8],
                                                      cfg.match_case)) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign match = bytes_eq && (cfg.target_length != 4'd0) &&
                 (4'(word_count) == cfg.target_length);

  assign repl_len = (cfg.replacement_length > 4'(WORD_MAX)) ? CNT_W'(WORD_MAX)
                                                            : CNT_W'(cfg.replacement_length);

  always_comb begin
    cmd             = '0;
    push            = 1'b0;
    store_we        = 1'b0;
    word_count_next = word_count;
    passing_next    = passing;
    any_out_next    = any_out;
    if (accept) begin
      if (in_ch.end_mark || in_ch.text_byte == cfg.delimiter) begin
        // word end
        if (passing) begin
          passing_next = 1'b0;
        end else if (word_count != '0) begin
          cmd.sep         = any_out;
          cmd.body        = match ? cfg.replacement_word[BODY_W-1:0] : word_vec;
          cmd.body_len    = match ? repl_len : word_count;
          // empty replacement with no separator yields no results
          push            = cmd.sep || (cmd.body_len != '0);
          any_out_next    = 1'b1;
          word_count_next = '0;
        end
        if (in_ch.end_mark) begin
          cmd.eot         = 1'b1;
          push            = 1'b1;
          word_count_next = '0;
          passing_next    = 1'b0;
          any_out_next    = 1'b0;
        end
      end else if (passing) begin
        cmd.tail      = 1'b1;
        cmd.tail_byte = in_ch.text_byte;
        push          = 1'b1;
      end else if (word_count < CNT_W'(WORD_MAX)) begin
        store_we        = 1'b1;
        word_count_next = word_count + 1'b1;
      end else begin
        // overlong word: flush the buffer and stream the rest
        cmd.sep         = any_out;
        cmd.body        = word_vec;
        cmd.body_len    = word_count;
        cmd.tail        = 1'b1;
        cmd.tail_byte   = in_ch.text_byte;
        push            = 1'b1;
        word_count_next = '0;
        passing_next    = 1'b1;
        any_out_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
      passing    <= 1'b0;
      any_out    <= 1'b0;
    end else begin
      word_count <= word_count_next;
      passing    <= passing_next;
      any_out    <= any_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      word_store[word_count[IDX_W-1:0]] <= in_ch.text_byte;
    end
  end

endmodule

// ===== hw/rtl/wrf_queue.sv =====
// Short command queue between the front end and the back sequencer.
// Depends on wrf_pkg.
module wrf_queue
  import wrf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign full       = (fill == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/wrf_back.sv =====
// Back sequencer: expands each command into its run of result words, one
// per cycle while the output is not stalled, into the output register. Depends on wrf_pkg, wrf_if.
module wrf_back
  import wrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  wrf_out_if.source  out_ch
);

  logic             busy;
  cmd_t             cur;
  logic [RUN_W-1:0] step;
  logic [RUN_W-1:0] total;
  logic [RUN_W-1:0] body_pos;
  logic [RUN_W-1:0] len_ext;
  logic             emit;
  logic             last;
  logic [7:0]       r_byte;
  logic             r_valid;
  logic             r_eot;

  logic             out_valid;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             end_of_text;
  logic             last_of_run;

  assign len_ext  = RUN_W'(cur.body_len);
  assign total    = RUN_W'(cur.sep) + len_ext + RUN_W'(cur.tail) + RUN_W'(cur.eot);
  assign body_pos = step - RUN_W'(cur.sep);
  assign last     = (step == total - 1'b1);
  assign emit     = busy && (!out_valid || out_ch.ready);
  assign pop      = !busy && head_valid;

  always_comb begin
    r_byte  = 8'h00;
    r_valid = 1'b1;
    r_eot   = 1'b0;
    if (cur.sep && step == '0) begin
      r_byte = cfg.delimiter;
    end else if (body_pos < len_ext) begin
      r_byte = cur.body[{body_pos[IDX_W-1:0], 3'b000} +: 8];
    end else if (cur.tail && body_pos == len_ext) begin
      r_byte = cur.tail_byte;
    end else begin
      r_valid = 1'b0;
      r_eot   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      step <= '0;
    end else if (emit) begin
      step <= step + 1'b1;
    end
    if (emit) begin
      out_byte    <= r_byte;
      byte_valid  <= r_valid;
      end_of_text <= r_eot;
      last_of_run <= last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.byte_valid  = byte_valid;
  assign out_ch.end_of_text = end_of_text;
  assign out_ch.last_of_run = last_of_run;

endmodule

// ===== hw/rtl/word_replace_filter_core.sv =====
// Whole-word find and replace over a byte stream. The front end takes one text
// byte per cycle while its two-entry command queue has room; a buffered byte
// produces nothing. At a word end, an overlong word, a pass-through byte or the
// end mark, the back sequencer emits the run of results (up to ten) at one per
// cycle while the output is not stalled, and loads the next run only once the
// current one is done; its single output register sets the sustained rate.
// Registers sit at byte address 8*i on a 64-bit APB-style port; the user must
// write them only while the stream is idle, which the block does not enforce.
// Depends on wrf_pkg, wrf_if, wrf_front, wrf_queue, wrf_back.
module word_replace_filter_core
  import wrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  wrf_in_if.sink            in_ch,
  wrf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [63:0]          target_word;
  logic [3:0]           target_length;
  logic [63:0]          replacement_word;
  logic [3:0]           replacement_length;
  logic [7:0]           delimiter;
  logic                 match_case;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  cfg_t                 cfg;

  logic                 push;
  cmd_t                 push_cmd;
  logic                 q_full;
  logic                 head_valid;
  cmd_t                 head;
  logic                 pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_word        <= '0;
      target_length      <= '0;
      replacement_word   <= '0;
      replacement_length <= '0;
      delimiter          <= DELIMITER_RESET;
      match_case         <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_WORD:   target_word        <= pwdata;
        REG_TARGET_LENGTH: target_length      <= pwdata[3:0];
        REG_REPL_WORD:     replacement_word   <= pwdata;
        REG_REPL_LENGTH:   replacement_length <= pwdata[3:0];
        REG_DELIMITER:     delimiter          <= pwdata[7:0];
        REG_MATCH_CASE:    match_case         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET_WORD:   prdata = target_word;
      REG_TARGET_LENGTH: prdata = DATA_W'(target_length);
      REG_REPL_WORD:     prdata = replacement_word;
      REG_REPL_LENGTH:   prdata = DATA_W'(replacement_length);
      REG_DELIMITER:     prdata = DATA_W'(delimiter);
      REG_MATCH_CASE:    prdata = DATA_W'(match_case);
      default:           prdata = '0;
    endcase
  end

  assign cfg.target_word        = target_word;
  assign cfg.target_length      = target_length;
  assign cfg.replacement_word   = replacement_word;
  assign cfg.replacement_length = replacement_length;
  assign cfg.delimiter          = delimiter;
  assign cfg.match_case         = match_case;

  wrf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  wrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  wrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/wrf_checker.sv =====
// Port-level checks on the rewritten output stream, bound to the top level.
// Depends on word_replace_filter_core.
module wrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       end_of_text,
  input logic       last_of_run
);

  // a stalled word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid) &&
                                $stable(end_of_text) && $stable(last_of_run))
    else $error("output word changed while stalled");

  // the end marker carries no byte and closes its run
  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> !byte_valid && last_of_run && out_byte == 8'h00)
    else $error("end marker malformed");

  // a word without a byte is only ever the end marker
  a_nobyte_eot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_of_text)
    else $error("empty result that is not the end marker");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind word_replace_filter_core wrf_checker u_wrf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .byte_valid  (out_ch.byte_valid),
  .end_of_text (out_ch.end_of_text),
  .last_of_run (out_ch.last_of_run)
);
